### hdl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int CAP_W   = 4;
  localparam int OCC_W   = 4;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [3:0] CAP_RESET = 4'd8;
  localparam logic       REG_CAPACITY = 1'b0;  // register index, paddr[2]

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  // Command broadcast to every cell for one accepted item.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t fresh;
  } cmd_t;

endpackage
`default_nettype wire

### hdl/spq_cell.sv
// One storage cell of the sorted shift chain.
`default_nettype none
module spq_cell (
  input  wire logic           clk,
  input  wire spq_pkg::cmd_t  cmd,
  input  wire logic           occupied,
  input  wire logic           left_ge,
  input  wire spq_pkg::entry_t left_entry,
  input  wire spq_pkg::entry_t right_entry,
  output spq_pkg::entry_t     entry,
  output spq_pkg::entry_t     entry_next,
  output logic                ge
);
  import spq_pkg::*;

  // Entry stays in place when it ranks ahead of (or ties with) the new item.
  assign ge = occupied && ($signed(entry.prio) >= $signed(cmd.fresh.prio));

  always_comb begin
    entry_next = entry;
    if (cmd.push) begin
      if (!ge) begin
        entry_next = left_ge ? cmd.fresh : left_entry;
      end
    end else if (cmd.pop) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

### hdl/sorted_priority_queue.sv
// Top level: sorted priority queue built from a chain of shift cells.
//
//  channel | dir | handshake          | contents
//  s_*     | in  | s_tvalid/s_tready  | tuser: kind; tdata: item_value, item_priority
//  m_*     | out | m_tvalid/m_tready  | tuser: status; tdata: popped, head, valid, occupancy
//  apb     | in  | psel/penable/pready| capacity_limit at byte address 0
//
// One item per cycle: every cell compares its priority with the new item in
// parallel and moves one place in the same cycle, so a push or pop finishes
// in the cycle it is accepted. The result sits in an output register; a new
// item is taken while that register is empty or being drained.
// rst clears the count and output valid and sets capacity to 8; cell contents
// are not reset.
`default_nettype none
module sorted_priority_queue #(
  parameter int DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // [31:0] item_value, [47:32] item_priority
  input  wire logic        s_tuser,   // [0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // [31:0] popped_value, [63:32] head_value,
                                      // [64] head_valid, [68:65] occupancy, zero pad
  output logic [1:0]       m_tuser,   // [1:0] status
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [LW-1:0]    cap_ext;
  logic [LW-1:0]    limit;
  logic [LW-1:0]    count_ext;
  logic [LW-1:0]    count_next_ext;
  logic             accept;
  logic             is_full;
  logic             is_empty;
  cmd_t             cmd;
  status_t          status_next;
  logic [VALUE_W-1:0] popped_next;
  logic [VALUE_W-1:0] head_next;

  entry_t ents  [DEPTH];
  entry_t nexts [DEPTH];
  logic   ges   [DEPTH];

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, capacity} : 32'd0;

  assign cap_ext   = LW'(capacity);
  assign count_ext = LW'(count);
  assign limit     = (cap_ext < LW'(DEPTH)) ? cap_ext : LW'(DEPTH);
  assign is_full   = (count_ext >= limit);
  assign is_empty  = (count == '0);

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd.push        = accept && (s_tuser == KIND_PUSH) && !is_full;
    cmd.pop         = accept && (s_tuser == KIND_POP) && !is_empty;
    cmd.fresh.value = s_tdata[31:0];
    cmd.fresh.prio  = s_tdata[47:32];
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic   left_ge;
      entry_t left_entry;
      entry_t right_entry;
      if (i == 0) begin : g_first
        assign left_ge    = 1'b1;
        assign left_entry = cmd.fresh;
      end else begin : g_mid
        assign left_ge    = ges[i-1];
        assign left_entry = ents[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_entry = ents[i];
      end else begin : g_inner
        assign right_entry = ents[i+1];
      end
      spq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occupied    (count > CW'(i)),
        .left_ge     (left_ge),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .entry       (ents[i]),
        .entry_next  (nexts[i]),
        .ge          (ges[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    status_next = ST_DONE;
    if (s_tuser == KIND_PUSH) begin
      if (is_full) status_next = ST_FULL;
    end else begin
      if (is_empty) status_next = ST_EMPTY;
    end
  end

  assign count_next_ext = LW'(count_next);
  assign popped_next    = cmd.pop ? ents[0].value : '0;
  assign head_next      = (count_next != '0) ? nexts[0].value : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= status_next;
      m_tdata <= {3'b000, count_next_ext[OCC_W-1:0], (count_next != '0),
                  head_next, popped_next};
    end
  end

endmodule
`default_nettype wire

### hdl/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
`default_nettype none
module spq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic [1:0]  m_tuser
);
  import spq_pkg::*;

  // A result's head flag agrees with its occupancy.
  a_head_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[64] == (m_tdata[68:65] != 4'd0)))
    else $error("head_valid disagrees with occupancy");

  // Failed steps (full or empty status) never carry a popped value.
  a_popped_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_DONE) |-> (m_tdata[31:0] == 32'd0))
    else $error("popped value on a failed step");

  // Pop on empty leaves an empty queue.
  a_empty_stays: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[68:65] == 4'd0 && m_tdata[63:32] == 32'd0))
    else $error("pop on empty reported entries");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
